### hw/rtl/rtc_pkg.sv
package rtc_pkg;

  parameter int unsigned MAX_TEXT_DEF = 64;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd1;
  localparam int unsigned CFG_DATA_W = 7;

  // Result error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_DIGIT   = 3'd1;
  localparam logic [2:0] ERR_INVALID = 3'd2;
  localparam logic [2:0] ERR_EMPTY   = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG = 3'd4;

  typedef struct packed {
    logic load;       // store one input item
    logic setup;      // start the permute walk
    logic perm_step;  // move one character through the permutation
    logic emit_rd;    // read the next permuted character
    logic emit_ld;    // load the output register with it
    logic load_err;   // load the output register with an error item
    logic clr;        // drop the text state
  } rtc_cmd_t;

  typedef struct packed {
    logic [2:0] err;
    logic       perm_last;
    logic       out_last;
  } rtc_sts_t;

endpackage

### hw/rtl/rtc_dpath.sv
module rtc_dpath #(
  parameter int unsigned MaxText = rtc_pkg::MAX_TEXT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rtc_pkg::rtc_cmd_t                 cmd_i,
  output rtc_pkg::rtc_sts_t                 sts_o,
  input  logic [7:0]                        char_i,
  input  logic                              last_i,
  input  logic                              cfg_we_i,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rtc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [7:0]                        out_char_o,
  output logic [2:0]                        out_err_o,
  output logic                              out_last_o
);
  import rtc_pkg::*;

  localparam int unsigned LenW = $clog2(MaxText + 1);
  localparam int unsigned AW   = (MaxText > 1) ? $clog2(MaxText) : 1;
  localparam int unsigned SumW = ((LenW > CFG_DATA_W) ? LenW : CFG_DATA_W) + 1;

  logic [7:0] text_mem [MaxText];
  logic [7:0] perm_mem [MaxText];

  logic [CFG_DATA_W-1:0] cols_q;
  logic                  dec_q;
  logic [LenW-1:0]       len_q, k_q, pos_q, col_q, j_q;
  logic                  dig_q, bad_q, ovf_q;
  logic [AW-1:0]         wr_addr_q;
  logic                  wr_en_q;
  logic [7:0]            text_rd_q, perm_rd_q;
  logic [7:0]            out_char_q;
  logic [2:0]            out_err_q;
  logic                  out_last_q;

  logic            is_end, is_digit, is_upper, is_lower, is_bad, has_room;
  logic [7:0]      ch;
  logic [2:0]      err;
  logic [CFG_DATA_W-1:0] eff_cols;
  logic [SumW-1:0] cols_w, len_w, cstart_w, pos_sum;
  logic            wrap;
  logic [AW-1:0]   text_rd_addr;

  always_comb begin
    is_end   = last_i && (char_i == 8'd0);
    is_digit = (char_i inside {[8'h30:8'h39]});
    is_upper = (char_i inside {[8'h41:8'h5A]});
    is_lower = (char_i inside {[8'h61:8'h7A]});
    is_bad   = dec_q ? !is_upper : !(is_upper || is_lower);
    ch       = is_lower ? (char_i - 8'd32) : char_i;
    has_room = (len_q < LenW'(MaxText));
  end

  always_comb begin
    if (dig_q)               err = ERR_DIGIT;
    else if (bad_q)          err = ERR_INVALID;
    else if (len_q == '0)    err = ERR_EMPTY;
    else if (ovf_q)          err = ERR_TOO_LONG;
    else                     err = ERR_NONE;
  end

  // Column walk: columns right to left, each top to bottom
  always_comb begin
    eff_cols     = (cols_q == '0) ? CFG_DATA_W'(1) : cols_q;
    cols_w       = SumW'(eff_cols);
    len_w        = SumW'(len_q);
    cstart_w     = ((cols_w > len_w) ? len_w : cols_w) - SumW'(1);
    pos_sum      = SumW'(pos_q) + cols_w;
    wrap         = (pos_sum >= len_w);
    text_rd_addr = dec_q ? k_q[AW-1:0] : pos_q[AW-1:0];
  end

  assign sts_o.err       = err;
  assign sts_o.perm_last = wrap && (col_q == '0);
  assign sts_o.out_last  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= CFG_DATA_W'(1);
      dec_q   <= 1'b0;
      len_q   <= '0;
      dig_q   <= 1'b0;
      bad_q   <= 1'b0;
      ovf_q   <= 1'b0;
      wr_en_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COLUMN_COUNT: cols_q <= cfg_data_i;
          REG_DECRYPT_MODE: dec_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      wr_en_q <= cmd_i.perm_step;
      if (cmd_i.load && !is_end) begin
        if (is_digit)    dig_q <= 1'b1;
        else if (is_bad) bad_q <= 1'b1;
        if (has_room)    len_q <= len_q + LenW'(1);
        else             ovf_q <= 1'b1;
      end
      if (cmd_i.clr) begin
        len_q <= '0;
        dig_q <= 1'b0;
        bad_q <= 1'b0;
        ovf_q <= 1'b0;
      end
    end
  end

  // Walk counters and output item
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      col_q <= cstart_w[LenW-1:0];
      pos_q <= cstart_w[LenW-1:0];
      k_q   <= '0;
      j_q   <= '0;
    end
    if (cmd_i.perm_step) begin
      wr_addr_q <= dec_q ? pos_q[AW-1:0] : k_q[AW-1:0];
      k_q       <= k_q + LenW'(1);
      if (wrap) begin
        col_q <= col_q - LenW'(1);
        pos_q <= col_q - LenW'(1);
      end else begin
        pos_q <= pos_sum[LenW-1:0];
      end
    end
    if (cmd_i.emit_ld) begin
      out_char_q <= perm_rd_q;
      out_err_q  <= ERR_NONE;
      out_last_q <= ((j_q + LenW'(1)) == len_q);
      j_q        <= j_q + LenW'(1);
    end
    if (cmd_i.load_err) begin
      out_char_q <= 8'd0;
      out_err_q  <= err;
      out_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !is_end && has_room) text_mem[len_q[AW-1:0]] <= ch;
    if (cmd_i.perm_step) text_rd_q <= text_mem[text_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_q) perm_mem[wr_addr_q] <= text_rd_q;
    if (cmd_i.emit_rd) perm_rd_q <= perm_mem[j_q[AW-1:0]];
  end

  assign out_char_o = out_char_q;
  assign out_err_o  = out_err_q;
  assign out_last_o = out_last_q;

endmodule

### hw/rtl/rtc_ctrl.sv
module rtc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rtc_pkg::rtc_sts_t sts_i,
  output rtc_pkg::rtc_cmd_t cmd_o
);
  import rtc_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DECIDE,
    ST_PERM,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } state_e;

  state_e state_q;
  logic   ready_q, valid_q;
  logic   taken;

  assign taken = valid_q && out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = ready_q && in_valid_i;
    cmd_o.setup     = (state_q == ST_DECIDE) && (sts_i.err == ERR_NONE);
    cmd_o.load_err  = (state_q == ST_DECIDE) && (sts_i.err != ERR_NONE);
    cmd_o.perm_step = (state_q == ST_PERM);
    cmd_o.emit_rd   = (state_q == ST_EMIT_RD) ||
                      ((state_q == ST_EMIT_OUT) && taken && !sts_i.out_last);
    cmd_o.emit_ld   = (state_q == ST_EMIT_LD);
    cmd_o.clr       = (state_q == ST_EMIT_OUT) && taken && sts_i.out_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      ready_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_valid_i && in_last_i) begin
            state_q <= ST_DECIDE;
            ready_q <= 1'b0;
          end
        end
        ST_DECIDE: begin
          if (sts_i.err != ERR_NONE) begin
            state_q <= ST_EMIT_OUT;
            valid_q <= 1'b1;
          end else begin
            state_q <= ST_PERM;
          end
        end
        ST_PERM: begin
          if (sts_i.perm_last) state_q <= ST_DRAIN;
        end
        // let the final permute write land before reading back
        ST_DRAIN:   state_q <= ST_EMIT_RD;
        ST_EMIT_RD: state_q <= ST_EMIT_LD;
        ST_EMIT_LD: begin
          state_q <= ST_EMIT_OUT;
          valid_q <= 1'b1;
        end
        ST_EMIT_OUT: begin
          if (taken) begin
            valid_q <= 1'b0;
            if (sts_i.out_last) begin
              state_q <= ST_LOAD;
              ready_q <= 1'b1;
            end else begin
              state_q <= ST_EMIT_LD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
          ready_q <= 1'b1;
          valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = ready_q;
  assign out_valid_o = valid_q;

endmodule

### hw/rtl/route_transposition_cipher.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata[7:0] char_code, tlast last_char
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata[7:0] out_char,
//                                                     tuser[2:0] error_code, tlast last_out
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Characters load at one item per cycle while s_axis_tready is high. After the last one: a decode
// state, then the permute walk moves each character from the text store to the permuted store,
// then a drain state and a read-back state, then a load and an output state per result item.
// An error result is loaded in the decode state, with no permute walk.
// Reset clears the text state and sets one column, encrypt mode; no input is taken
// while results are pending, and an output stall holds the read-back of the next item.
module route_transposition_cipher #(
  parameter int unsigned MaxText = rtc_pkg::MAX_TEXT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] char_code
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] out_char
  output logic [2:0]                     m_axis_tuser,   // [2:0] error_code
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rtc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rtc_pkg::*;

  rtc_cmd_t cmd;
  rtc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rtc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rtc_dpath #(
    .MaxText (MaxText)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .char_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_char_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_err_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ERR_NONE) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("error item malformed");

  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("input not reopened after final item");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after last character");

endmodule
